@@ rtl/diag_srr_pkg.sv @@
// Shared types and constants of the diagnostic service request router.
package diag_srr_pkg;

  // Operation codes of an input transaction.
  localparam logic [2:0] OP_ROUTE        = 3'd0;
  localparam logic [2:0] OP_ADD_SERVICE  = 3'd1;
  localparam logic [2:0] OP_ADD_READ_ID  = 3'd2;
  localparam logic [2:0] OP_ADD_WRITE_ID = 3'd3;
  localparam logic [2:0] OP_ADD_ROUTINE  = 3'd4;

  // Result status codes.
  localparam logic [2:0] STAT_OK           = 3'd0;
  localparam logic [2:0] STAT_ZERO_KEY     = 3'd1;
  localparam logic [2:0] STAT_DUPLICATE    = 3'd2;
  localparam logic [2:0] STAT_TABLE_FULL   = 3'd3;
  localparam logic [2:0] STAT_SESSION_FULL = 3'd4;

  // Table selects.
  localparam logic [1:0] TBL_SERVICE  = 2'd0;
  localparam logic [1:0] TBL_READ_ID  = 2'd1;
  localparam logic [1:0] TBL_WRITE_ID = 2'd2;
  localparam logic [1:0] TBL_ROUTINE  = 2'd3;

  // UDS service ids.
  localparam logic [7:0] SID_READ_ID       = 8'h22;
  localparam logic [7:0] SID_WRITE_ID      = 8'h2E;
  localparam logic [7:0] SID_ROUTINE       = 8'h31;
  localparam logic [7:0] SID_DOWNLOAD      = 8'h34;
  localparam logic [7:0] SID_UPLOAD        = 8'h35;
  localparam logic [7:0] SID_TRANSFER_DATA = 8'h36;
  localparam logic [7:0] SID_TRANSFER_EXIT = 8'h37;
  localparam logic [7:0] SID_FILE_TRANSFER = 8'h38;

  localparam logic [7:0] SID_NONE = 8'h00;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] entry_key;
    logic [7:0]  entry_processor;
    logic [7:0]  request_sid;
    logic [15:0] tester_addr;
    logic [11:0] payload_length;
    logic [7:0]  payload_byte1;
    logic [7:0]  payload_byte2;
    logic [7:0]  payload_byte3;
  } item_t;

  typedef struct packed {
    logic [7:0] target_processor;
    logic [2:0] status;
  } result_t;

  // One stored entry: table key or session source address, with its processor.
  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  proc;
  } slot_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_TSCAN  = 7'b0000100,
    S_TEND   = 7'b0001000,
    S_SSCAN  = 7'b0010000,
    S_SEND   = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_e;

endpackage

@@ rtl/diag_srr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module diag_srr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 264,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/diag_service_request_router_core.sv @@
// Top level of the diagnostic service request router: sequencer, entry scan and result register.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (diag_srr_pkg::item_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (diag_srr_pkg::result_t)
//
// Flow: one transaction at a time. An insert scans the filled entries of its target table
//   until a hit; a route scans its table the same way, then for a session service the session
//   store. After the result state the block goes back to idle before the next acceptance.
//   Scans use the single RAM read port, one entry a cycle, and one shared key comparator.
// Reset: fill counts and session valid bits clear at once; no clearing pass over the RAM.
// Stalls: the result register holds a result while out_stall_i is high; a new transaction is
//   accepted meanwhile, and its result waits in the result state until the register frees.
module diag_service_request_router_core #(
  parameter int unsigned TABLE_DEPTH   = 64,
  parameter int unsigned SESSION_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  diag_srr_pkg::item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output diag_srr_pkg::result_t out_data_o
);

  // Four lookup tables back to back, then the session store, all in one RAM.
  localparam int unsigned RAM_DEPTH = 4 * TABLE_DEPTH + SESSION_DEPTH;
  localparam int unsigned AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int unsigned CW        = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SCAN_MAX  = (TABLE_DEPTH > SESSION_DEPTH) ? TABLE_DEPTH
                                                                    : SESSION_DEPTH;
  localparam int unsigned SW        = $clog2(SCAN_MAX + 1);
  localparam int unsigned SIW       = (SESSION_DEPTH > 1) ? $clog2(SESSION_DEPTH) : 1;
  localparam int unsigned SLOT_W    = $bits(diag_srr_pkg::slot_t);

  localparam logic [AW-1:0] SESS_BASE = AW'(4 * TABLE_DEPTH);
  localparam logic [CW-1:0] TBL_FULL  = CW'(TABLE_DEPTH);

  diag_srr_pkg::state_e  state_q, state_d;
  diag_srr_pkg::item_t   item_q;
  diag_srr_pkg::result_t out_q;
  logic                  out_valid_q;

  logic [1:0]         tbl_q;
  logic [15:0]        key_q;
  logic               is_insert_q;
  logic               sess_q;
  logic [SW-1:0]      scan_idx_q;
  logic [SW-1:0]      lim_q;
  logic               rd_pend_q;
  logic [SW-1:0]      rd_idx_q;
  logic               hit_q;
  logic [SIW-1:0]     hit_idx_q;
  logic [7:0]         hit_proc_q;
  logic               free_found_q;
  logic [SIW-1:0]     free_idx_q;
  logic [7:0]         proc_q;
  logic [2:0]         status_q;
  logic [CW-1:0]      cnt_q [4];
  logic [SESSION_DEPTH-1:0] valid_q;

  // Decode of the held transaction.
  logic        op_insert, op_route;
  logic [1:0]  dec_tbl;
  logic [15:0] dec_key;
  logic        sid_session, sid_opener;

  // Scan datapath.
  diag_srr_pkg::slot_t rd_slot;
  logic [SLOT_W-1:0]   rd_raw;
  logic                scanning, rd_ok, cmp_hit, issue, scan_over;
  logic [AW-1:0]       tbl_base, raddr, waddr;
  logic                ram_we;
  diag_srr_pkg::slot_t wr_slot;
  logic                ins_wr, sess_wr;
  logic                out_free;

  always_comb begin
    op_insert = (item_q.op == diag_srr_pkg::OP_ADD_SERVICE)  ||
                (item_q.op == diag_srr_pkg::OP_ADD_READ_ID)  ||
                (item_q.op == diag_srr_pkg::OP_ADD_WRITE_ID) ||
                (item_q.op == diag_srr_pkg::OP_ADD_ROUTINE);
    op_route  = (item_q.op == diag_srr_pkg::OP_ROUTE);
    dec_tbl   = diag_srr_pkg::TBL_SERVICE;
    dec_key   = {diag_srr_pkg::SID_NONE, item_q.request_sid};
    if (op_insert) begin
      // Insert ops map one to one onto the four tables.
      dec_tbl = item_q.op[1:0] - 2'd1;
      dec_key = item_q.entry_key;
    end else begin
      case (item_q.request_sid)
        diag_srr_pkg::SID_READ_ID: begin
          dec_tbl = diag_srr_pkg::TBL_READ_ID;
          // Short payload: identifier is zero, which no entry holds.
          dec_key = (item_q.payload_length > 12'd2) ?
                    {item_q.payload_byte1, item_q.payload_byte2} : 16'd0;
        end
        diag_srr_pkg::SID_WRITE_ID: begin
          dec_tbl = diag_srr_pkg::TBL_WRITE_ID;
          dec_key = (item_q.payload_length > 12'd2) ?
                    {item_q.payload_byte1, item_q.payload_byte2} : 16'd0;
        end
        diag_srr_pkg::SID_ROUTINE: begin
          dec_tbl = diag_srr_pkg::TBL_ROUTINE;
          dec_key = (item_q.payload_length > 12'd3) ?
                    {item_q.payload_byte2, item_q.payload_byte3} : 16'd0;
        end
        default: begin
          dec_tbl = diag_srr_pkg::TBL_SERVICE;
          dec_key = {diag_srr_pkg::SID_NONE, item_q.request_sid};
        end
      endcase
    end
    sid_session = (item_q.request_sid >= diag_srr_pkg::SID_DOWNLOAD) &&
                  (item_q.request_sid <= diag_srr_pkg::SID_FILE_TRANSFER);
    sid_opener  = (item_q.request_sid == diag_srr_pkg::SID_DOWNLOAD) ||
                  (item_q.request_sid == diag_srr_pkg::SID_UPLOAD)   ||
                  (item_q.request_sid == diag_srr_pkg::SID_FILE_TRANSFER);
  end

  // Scan: issue one read a cycle, compare the entry read in the cycle before.
  assign rd_slot   = diag_srr_pkg::slot_t'(rd_raw);
  assign scanning  = (state_q == diag_srr_pkg::S_TSCAN) || (state_q == diag_srr_pkg::S_SSCAN);
  assign rd_ok     = !sess_q || valid_q[rd_idx_q[SIW-1:0]];
  assign cmp_hit   = scanning && rd_pend_q && rd_ok && (rd_slot.key == key_q);
  assign issue     = scanning && (scan_idx_q < lim_q) && !cmp_hit;
  assign scan_over = scanning && (cmp_hit || (!issue && !rd_pend_q));

  assign tbl_base = AW'(tbl_q) * AW'(TABLE_DEPTH);
  assign raddr    = (sess_q ? SESS_BASE : tbl_base) + AW'(scan_idx_q);

  assign ins_wr  = (state_q == diag_srr_pkg::S_TEND) && is_insert_q && !hit_q &&
                   (cnt_q[tbl_q] != TBL_FULL);
  assign sess_wr = (state_q == diag_srr_pkg::S_SEND) && sid_opener && (hit_q || free_found_q);
  assign ram_we  = ins_wr || sess_wr;

  always_comb begin
    if (sess_wr) begin
      waddr        = SESS_BASE + AW'(hit_q ? hit_idx_q : free_idx_q);
      wr_slot.key  = key_q;
      wr_slot.proc = proc_q;
    end else begin
      waddr        = tbl_base + AW'(cnt_q[tbl_q]);
      wr_slot.key  = key_q;
      wr_slot.proc = item_q.entry_processor;
    end
  end

  diag_srr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wr_slot),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rd_raw)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      diag_srr_pkg::S_IDLE: begin
        if (in_valid_i) state_d = diag_srr_pkg::S_DECODE;
      end
      diag_srr_pkg::S_DECODE: begin
        if ((op_insert && (item_q.entry_key != 16'd0)) || op_route) begin
          state_d = diag_srr_pkg::S_TSCAN;
        end else begin
          state_d = diag_srr_pkg::S_RESULT;
        end
      end
      diag_srr_pkg::S_TSCAN: begin
        if (scan_over) state_d = diag_srr_pkg::S_TEND;
      end
      diag_srr_pkg::S_TEND: begin
        state_d = (!is_insert_q && sid_session) ? diag_srr_pkg::S_SSCAN
                                                : diag_srr_pkg::S_RESULT;
      end
      diag_srr_pkg::S_SSCAN: begin
        if (scan_over) state_d = diag_srr_pkg::S_SEND;
      end
      diag_srr_pkg::S_SEND: begin
        state_d = diag_srr_pkg::S_RESULT;
      end
      diag_srr_pkg::S_RESULT: begin
        if (out_free) state_d = diag_srr_pkg::S_IDLE;
      end
      default: state_d = diag_srr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= diag_srr_pkg::S_IDLE;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      sess_q       <= 1'b0;
      is_insert_q  <= 1'b0;
      scan_idx_q   <= '0;
      lim_q        <= '0;
    end else begin
      state_q <= state_d;

      // Load the result register from the result state; drop a result once it is taken.
      if ((state_q == diag_srr_pkg::S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Track the pipelined read in both scans.
      if (scanning) begin
        rd_pend_q <= issue;
        rd_idx_q  <= scan_idx_q;
        if (issue) scan_idx_q <= scan_idx_q + SW'(1);
        if (cmp_hit) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= rd_idx_q[SIW-1:0];
          hit_proc_q <= rd_slot.proc;
        end
      end

      unique case (state_q)
        diag_srr_pkg::S_IDLE: begin
          if (in_valid_i) item_q <= in_data_i;
        end
        diag_srr_pkg::S_DECODE: begin
          // Set up the table scan; ignored ops and zero keys finish here.
          tbl_q        <= dec_tbl;
          key_q        <= dec_key;
          is_insert_q  <= op_insert;
          sess_q       <= 1'b0;
          scan_idx_q   <= '0;
          lim_q        <= SW'(cnt_q[dec_tbl]);
          rd_pend_q    <= 1'b0;
          hit_q        <= 1'b0;
          proc_q       <= 8'd0;
          status_q     <= (op_insert && (item_q.entry_key == 16'd0)) ?
                          diag_srr_pkg::STAT_ZERO_KEY : diag_srr_pkg::STAT_OK;
        end
        diag_srr_pkg::S_TEND: begin
          if (is_insert_q) begin
            if (hit_q) begin
              status_q <= diag_srr_pkg::STAT_DUPLICATE;
            end else if (cnt_q[tbl_q] == TBL_FULL) begin
              status_q <= diag_srr_pkg::STAT_TABLE_FULL;
            end else begin
              cnt_q[tbl_q] <= cnt_q[tbl_q] + CW'(1);
            end
          end else begin
            proc_q <= hit_q ? hit_proc_q : 8'd0;
            // Set up the session scan keyed by source address.
            sess_q       <= 1'b1;
            key_q        <= item_q.tester_addr;
            scan_idx_q   <= '0;
            lim_q        <= SW'(SESSION_DEPTH);
            rd_pend_q    <= 1'b0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
          end
        end
        diag_srr_pkg::S_SSCAN: begin
          // Remember the lowest free session slot as the scan passes it.
          if (issue && !valid_q[scan_idx_q[SIW-1:0]] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= scan_idx_q[SIW-1:0];
          end
        end
        diag_srr_pkg::S_SEND: begin
          if (sid_opener) begin
            if (!hit_q) begin
              if (free_found_q) begin
                valid_q[free_idx_q] <= 1'b1;
              end else begin
                status_q <= diag_srr_pkg::STAT_SESSION_FULL;
              end
            end
          end else if (hit_q) begin
            proc_q <= hit_proc_q;
            if (item_q.request_sid == diag_srr_pkg::SID_TRANSFER_EXIT) begin
              valid_q[hit_idx_q] <= 1'b0;
            end
          end
        end
        diag_srr_pkg::S_RESULT: begin
          if (out_free) begin
            out_q.target_processor <= proc_q;
            out_q.status           <= status_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != diag_srr_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result only comes out of the result state.
  a_result_from_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == diag_srr_pkg::S_RESULT))
    else $error("result appeared outside the result state");

  // Fill counts never pass the table depth.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= TBL_FULL) && (cnt_q[1] <= TBL_FULL) &&
    (cnt_q[2] <= TBL_FULL) && (cnt_q[3] <= TBL_FULL))
    else $error("table fill count beyond depth");

  // The scan index never runs past its limit.
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scanning |-> (scan_idx_q <= lim_q))
    else $error("scan index beyond limit");

  // A session hit always names a live session.
  a_sess_hit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == diag_srr_pkg::S_SEND) && hit_q) |-> valid_q[hit_idx_q])
    else $error("session hit on a free slot");

endmodule

@@ tb/sv/diag_service_request_router_core_checker.sv @@
// Checker for the diagnostic service request router: predicts every result and compares it.
`timescale 1ns / 100ps
module diag_service_request_router_core_checker
  import diag_srr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH   = 64,
  parameter int unsigned SESSION_DEPTH = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_stall_i,
  input  item_t   in_data_i,
  input  logic    out_valid_i,
  input  logic    out_stall_i,
  input  result_t out_data_i,
  output int      fail_count_o,
  output int      pending_o
);

  typedef struct packed {
    logic        valid;
    logic [15:0] key;
    logic [7:0]  proc;
  } entry_t;

  entry_t  tables [4][TABLE_DEPTH];
  entry_t  sessions [SESSION_DEPTH];
  result_t expected_results [$];
  result_t want;

  task automatic report_mismatch(string what, logic [10:0] got, logic [10:0] exp_val);
    $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
    fail_count_o++;
  endtask

  function automatic logic [7:0] find_processor(logic [1:0] tsel, logic [15:0] key);
    logic [7:0] proc;
    proc = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tables[tsel][i].valid && tables[tsel][i].key == key) proc = tables[tsel][i].proc;
    end
    return proc;
  endfunction

  // Reject zero keys and duplicates, then place into the lowest free slot.
  function automatic logic [2:0] add_entry(logic [1:0] tsel, logic [15:0] key,
                                           logic [7:0] proc);
    int  free_slot;
    bit  dup;
    free_slot = -1;
    dup       = 1'b0;
    if (key == '0) return STAT_ZERO_KEY;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tables[tsel][i].valid && tables[tsel][i].key == key) dup = 1'b1;
      else if (!tables[tsel][i].valid && free_slot < 0) free_slot = i;
    end
    if (dup) return STAT_DUPLICATE;
    if (free_slot < 0) return STAT_TABLE_FULL;
    tables[tsel][free_slot] = {1'b1, key, proc};
    return STAT_OK;
  endfunction

  function automatic int find_session(logic [15:0] addr, bit want_free);
    int hit;
    hit = -1;
    for (int i = 0; i < SESSION_DEPTH; i++) begin
      if (hit < 0) begin
        if (want_free && !sessions[i].valid) hit = i;
        if (!want_free && sessions[i].valid && sessions[i].key == addr) hit = i;
      end
    end
    return hit;
  endfunction

  function automatic result_t serve_request(item_t it);
    result_t     res;
    logic [15:0] ident;
    logic [7:0]  sid;
    int          slot;
    bit          opener;
    res   = '0;
    ident = '0;
    sid   = it.request_sid;
    case (it.op)
      OP_ADD_SERVICE:  res.status = add_entry(TBL_SERVICE, it.entry_key, it.entry_processor);
      OP_ADD_READ_ID:  res.status = add_entry(TBL_READ_ID, it.entry_key, it.entry_processor);
      OP_ADD_WRITE_ID: res.status = add_entry(TBL_WRITE_ID, it.entry_key, it.entry_processor);
      OP_ADD_ROUTINE:  res.status = add_entry(TBL_ROUTINE, it.entry_key, it.entry_processor);
      OP_ROUTE: begin
        if (sid == SID_READ_ID || sid == SID_WRITE_ID) begin
          if (it.payload_length > 12'd2) ident = {it.payload_byte1, it.payload_byte2};
          res.target_processor =
            find_processor(sid == SID_READ_ID ? TBL_READ_ID : TBL_WRITE_ID, ident);
        end else if (sid == SID_ROUTINE) begin
          if (it.payload_length > 12'd3) ident = {it.payload_byte2, it.payload_byte3};
          res.target_processor = find_processor(TBL_ROUTINE, ident);
        end else begin
          res.target_processor = find_processor(TBL_SERVICE, {8'h00, sid});
        end
        if (sid >= SID_DOWNLOAD && sid <= SID_FILE_TRANSFER) begin
          opener = (sid == SID_DOWNLOAD || sid == SID_UPLOAD || sid == SID_FILE_TRANSFER);
          slot   = find_session(it.tester_addr, 1'b0);
          if (slot >= 0) begin
            if (opener) begin
              sessions[slot].proc = res.target_processor;
            end else begin
              res.target_processor = sessions[slot].proc;
              if (sid == SID_TRANSFER_EXIT) sessions[slot] = '0;
            end
          end else if (opener) begin
            slot = find_session(it.tester_addr, 1'b1);
            if (slot < 0) res.status = STAT_SESSION_FULL;
            else sessions[slot] = {1'b1, it.tester_addr, res.target_processor};
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < 4; t++) begin
        for (int i = 0; i < TABLE_DEPTH; i++) tables[t][i] = '0;
      end
      for (int i = 0; i < SESSION_DEPTH; i++) sessions[i] = '0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result without a pending transaction", out_data_i, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.target_processor !== want.target_processor) begin
            report_mismatch("target_processor", 11'(out_data_i.target_processor),
                            11'(want.target_processor));
          end
          if (out_data_i.status !== want.status) begin
            report_mismatch("status", 11'(out_data_i.status), 11'(want.status));
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(serve_request(in_data_i));
      pending_o = expected_results.size();
    end
  end

endmodule

@@ tb/sv/diag_service_request_router_core_test.sv @@
// Top of the router testbench: clock, reset, request stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps
module diag_service_request_router_core_test;
  import diag_srr_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 64;
  localparam int unsigned SESSION_DEPTH = 8;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 1950;
  // Drain twice the worst-case time of one transaction.
  localparam int DRAIN_CYCLES  = 2 * (TABLE_DEPTH + SESSION_DEPTH + 8);
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int POOL_DEPTH    = 256;
  localparam int TESTER_COUNT  = 12;
  localparam int STALL_PERCENT = 8;
  // Op codes the block leaves unused.
  localparam logic [2:0] OP_UNUSED_LO = OP_ADD_ROUTINE + 3'd1;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  item_t   in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_data_o;

  int fail_count;
  int pending;
  int cycle_count;

  // Shared between the sender and the receiver processes.
  bit jitter_on    = 1'b1;
  bit hold_request = 1'b0;

  // Keys offered so far per table, reused to make hits and duplicates likely.
  logic [15:0] used_keys [4][POOL_DEPTH];
  int          used_cnt  [4];
  // Small set of tester addresses so the session store fills up and gets reused.
  logic [15:0] testers [TESTER_COUNT];

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  diag_service_request_router_core #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SESSION_DEPTH(SESSION_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  diag_service_request_router_core_checker #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SESSION_DEPTH(SESSION_DEPTH)
  ) checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic item_t pack_item(logic [2:0] op, logic [15:0] key, logic [7:0] proc,
                                      logic [7:0] sid, logic [15:0] sa, logic [11:0] len,
                                      logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    return {op, key, proc, sid, sa, len, b1, b2, b3};
  endfunction

  // Offer one transaction. Entered and left at a falling edge. Insert a random gap first,
  // then hold valid and payload until a rising edge sees stall low.
  task automatic offer(item_t it);
    while (jitter_on && $urandom_range(0, 99) < STALL_PERCENT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    @(negedge clk_i);
  endtask

  // Receiver: drive stall at falling edges. A hold-off request keeps stall high for a long
  // stretch so results back up and the block stalls its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i  = 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
      end
      out_stall_i = jitter_on && ($urandom_range(0, 99) < STALL_PERCENT);
    end
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("diag_service_request_router_core: mismatch");
    $finish;
  end

  initial begin
    item_t       it;
    int          kind;
    int          pick;
    int          tsel;
    logic [15:0] key;

    rst_ni = 1'b0;
    for (int t = 0; t < 4; t++) used_cnt[t] = 0;
    for (int k = 0; k < TESTER_COUNT; k++) testers[k] = 16'($urandom);
    testers[0] = 16'h0000;
    testers[1] = 16'hFFFF;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty-table miss, zero key, duplicate, every table, short payloads,
    // session open / reuse / overwrite / exit, transfer without session, unused ops.
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, 8'h10, 16'h0000, 12'd1, 8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ADD_SERVICE, 16'h0000, 8'hFF, 8'hFF, 16'hFFFF, 12'hFFF,
                    8'hFF, 8'hFF, 8'hFF));
    offer(pack_item(OP_ADD_SERVICE, 16'h0010, 8'hFF, 8'h00, 16'h0000, 12'd0, 8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ADD_SERVICE, 16'h0010, 8'h01, 8'h00, 16'h0000, 12'd0, 8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ADD_SERVICE, 16'h0036, 8'h36, 8'h00, 16'h0000, 12'd0, 8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ADD_SERVICE, 16'h0037, 8'h37, 8'h00, 16'h0000, 12'd0, 8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ADD_SERVICE, 16'h0034, 8'h11, 8'h00, 16'h0000, 12'd0, 8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ADD_READ_ID, 16'hFFFF, 8'hA5, 8'h00, 16'h0000, 12'd0, 8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ADD_WRITE_ID, 16'h1234, 8'h5A, 8'h00, 16'h0000, 12'd0,
                    8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ADD_ROUTINE, 16'hFF00, 8'h80, 8'h00, 16'h0000, 12'd0, 8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, 8'h10, 16'h0000, 12'd1, 8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_READ_ID, 16'h0000, 12'd3,
                    8'hFF, 8'hFF, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_READ_ID, 16'h0000, 12'd2,
                    8'hFF, 8'hFF, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_WRITE_ID, 16'h0000, 12'hFFF,
                    8'h12, 8'h34, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_ROUTINE, 16'h0000, 12'd4,
                    8'h01, 8'hFF, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_ROUTINE, 16'h0000, 12'd3,
                    8'h01, 8'hFF, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_TRANSFER_DATA, 16'hFFFF, 12'd2,
                    8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_DOWNLOAD, 16'hFFFF, 12'd4,
                    8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_TRANSFER_DATA, 16'hFFFF, 12'd2,
                    8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_UPLOAD, 16'hFFFF, 12'd4,
                    8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_TRANSFER_EXIT, 16'hFFFF, 12'd1,
                    8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_TRANSFER_EXIT, 16'hFFFF, 12'd1,
                    8'h00, 8'h00, 8'h00));
    offer(pack_item(OP_UNUSED_HI, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 12'hFFF,
                    8'hFF, 8'hFF, 8'hFF));
    offer(pack_item(OP_UNUSED_LO, 16'hFFFF, 8'hFF, SID_DOWNLOAD, 16'hFFFF, 12'hFFF,
                    8'hFF, 8'hFF, 8'hFF));
    offer(pack_item(OP_ROUTE, 16'h0000, 8'h00, SID_NONE, 16'h0000, 12'd0, 8'h00, 8'h00, 8'h00));

    // Random: inserts that fill every table past its depth, routes that often look up stored
    // keys, and transfer traffic over a few testers so sessions open, fill and close.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      jitter_on = !(n >= 1000 && n < 1300);
      if (n == 600) hold_request = 1'b1;
      it = {3'(OP_ROUTE), 16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
            12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        it.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else if (kind < 40) begin
        tsel  = $urandom_range(0, 3);
        it.op = 3'(OP_ADD_SERVICE + tsel);
        pick  = $urandom_range(0, 15);
        if (pick == 0) key = '0;
        else if (pick < 5 && used_cnt[tsel] > 0)
          key = used_keys[tsel][$urandom_range(0, used_cnt[tsel] - 1)];
        else if (tsel == TBL_SERVICE && pick < 14) key = 16'($urandom_range(1, 255));
        else key = 16'($urandom);
        it.entry_key = key;
        if (key != '0 && used_cnt[tsel] < POOL_DEPTH) begin
          used_keys[tsel][used_cnt[tsel]] = key;
          used_cnt[tsel]++;
        end
      end else begin
        // Keep payloads short most of the time to sit on the length thresholds.
        if ($urandom_range(0, 7) != 0) it.payload_length = 12'($urandom_range(0, 6));
        if ($urandom_range(0, 9) != 0)
          it.tester_addr = testers[$urandom_range(0, TESTER_COUNT - 1)];
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
          it.request_sid = (kind == 0) ? SID_READ_ID : SID_WRITE_ID;
          tsel = (kind == 0) ? TBL_READ_ID : TBL_WRITE_ID;
          if (used_cnt[tsel] > 0 && $urandom_range(0, 3) != 0)
            {it.payload_byte1, it.payload_byte2} =
              used_keys[tsel][$urandom_range(0, used_cnt[tsel] - 1)];
        end else if (kind == 2) begin
          it.request_sid = SID_ROUTINE;
          if (used_cnt[TBL_ROUTINE] > 0 && $urandom_range(0, 3) != 0)
            {it.payload_byte2, it.payload_byte3} =
              used_keys[TBL_ROUTINE][$urandom_range(0, used_cnt[TBL_ROUTINE] - 1)];
        end else if (kind < 7) begin
          it.request_sid = 8'($urandom_range(SID_DOWNLOAD, SID_FILE_TRANSFER));
        end else if (used_cnt[TBL_SERVICE] > 0 && $urandom_range(0, 1) != 0) begin
          key = used_keys[TBL_SERVICE][$urandom_range(0, used_cnt[TBL_SERVICE] - 1)];
          it.request_sid = key[7:0];
        end
      end
      offer(it);
    end

    // Drop valid, drain every pending result, then give stray results a chance to show.
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("diag_service_request_router_core: match");
    end else begin
      $display("diag_service_request_router_core: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/diag_srr_pkg.sv
rtl/diag_srr_ram.sv
rtl/diag_service_request_router_core.sv
tb/sv/diag_service_request_router_core_checker.sv
tb/sv/diag_service_request_router_core_test.sv
